// ===== src/assert_macros.svh =====
// Assertion macros shared by the binner RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sgb_pkg.sv =====
// Shared types and codes for the sinogram pair binner.
// No dependencies.
`default_nettype none

package sgb_pkg;

    // Request opcodes
    localparam logic [2:0] ACT_PROMPT     = 3'd0;
    localparam logic [2:0] ACT_DELAYED    = 3'd1;
    localparam logic [2:0] ACT_LOAD       = 3'd2;
    localparam logic [2:0] ACT_RD_PROMPT  = 3'd3;
    localparam logic [2:0] ACT_RD_DELAYED = 3'd4;

    // Result status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_SAME  = 2'd1;
    localparam logic [1:0] STAT_NOBIN = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    // Fixed field widths
    localparam int BLOCK_W   = 4;
    localparam int CRYSTAL_W = 5;
    localparam int TKEY_W    = 18;
    localparam int TVAL_W    = 18;
    localparam int BIN_W     = 17;
    localparam int COUNT_W   = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_TABLE,
        ST_HIST
    } state_t;

endpackage

`default_nettype wire

// ===== src/sinogram_pair_binner_top.sv =====
// Sinogram pair binner: pair ordering, key-to-bin table and two histograms.
// Depends on sgb_pkg.sv and assert_macros.svh.
`default_nettype none

// Usage
//   Request channel: drive action and its operand ports with start high; the
//   request is taken on a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with status, bin_used and count.
//   The receiver cannot stall; every result must be taken in its cycle.
// Request flow (one request in flight at a time)
//   prompt/delayed pair that reaches the histogram: decode, table read,
//     histogram read and histogram write-back, then the result strobe.
//   counter read-back: decode and histogram read; table load, unused
//     opcode, or a pair rejected at decode: decode only; a pair rejected
//     by its table value: decode and table read.
//   The request rate is set by the single-port read-modify-write on the table
//   and histogram memories, each with a registered read.
// Reset
//   After rst_n is released busy stays high while a clearing pass zeroes
//   the table and both histograms, one address per cycle in parallel, over
//   max(NB*NB*CPB*CPB, SINO_BINS) addresses (147456 with default parameters).
// Counters are 16 bits and wrap from 65535 to 0.
module sinogram_pair_binner_top #(
    parameter int NUM_BLOCKS         = 12,
    parameter int CRYSTALS_PER_BLOCK = 32,
    parameter int SINO_BINS          = 72192
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        action,
    input  wire logic [sgb_pkg::BLOCK_W-1:0]       block_first,
    input  wire logic [sgb_pkg::CRYSTAL_W-1:0]     crystal_first,
    input  wire logic [sgb_pkg::BLOCK_W-1:0]       block_second,
    input  wire logic [sgb_pkg::CRYSTAL_W-1:0]     crystal_second,
    input  wire logic [sgb_pkg::TKEY_W-1:0]        table_key,
    input  wire logic signed [sgb_pkg::TVAL_W-1:0] table_value,
    input  wire logic [sgb_pkg::BIN_W-1:0]         bin_index,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic [sgb_pkg::BIN_W-1:0]              bin_used,
    output logic [sgb_pkg::COUNT_W-1:0]            count
);

    localparam int CPB        = CRYSTALS_PER_BLOCK;
    localparam int HB_STRIDE  = CPB * CPB;
    localparam int LB_STRIDE  = CPB * CPB * NUM_BLOCKS;
    localparam int PAIR_DEPTH = NUM_BLOCKS * NUM_BLOCKS * CPB * CPB;
    localparam int TBL_AW     = $clog2(PAIR_DEPTH);
    localparam int HIST_AW    = (SINO_BINS > 1) ? $clog2(SINO_BINS) : 1;
    localparam int CLR_DEPTH  = (PAIR_DEPTH > SINO_BINS) ? PAIR_DEPTH : SINO_BINS;
    localparam int CLR_CW     = $clog2(CLR_DEPTH);
    localparam int TW         = sgb_pkg::TVAL_W;
    localparam int CW         = sgb_pkg::COUNT_W;
    localparam int BW         = sgb_pkg::BLOCK_W;
    localparam int XW         = sgb_pkg::CRYSTAL_W;

    // ---------------- memories ----------------
    logic [TW-1:0] pair_table   [PAIR_DEPTH];
    logic [CW-1:0] prompt_hist  [SINO_BINS];
    logic [CW-1:0] delayed_hist [SINO_BINS];

    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_addr;
    logic [TW-1:0]       tbl_wdata;
    logic [TW-1:0]       tbl_rdata_reg;
    logic                p_we;
    logic                d_we;
    logic [HIST_AW-1:0]  hist_addr;
    logic [CW-1:0]       hist_wdata;
    logic [CW-1:0]       p_rdata_reg;
    logic [CW-1:0]       d_rdata_reg;

    // ---------------- control and request registers ----------------
    sgb_pkg::state_t     state_reg, state_next;
    logic [CLR_CW-1:0]   clr_cnt_reg;
    logic [2:0]          action_reg;
    logic [BW-1:0]       bf_reg, bs_reg;
    logic [XW-1:0]       cf_reg, cs_reg;
    logic [sgb_pkg::TKEY_W-1:0] tkey_reg;
    logic [TW-1:0]       tval_reg;
    logic [sgb_pkg::BIN_W-1:0]  bidx_reg;
    logic [HIST_AW-1:0]  bin_reg, bin_next;

    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [sgb_pkg::BIN_W-1:0]  bin_used_reg, bin_used_next;
    logic [CW-1:0]       count_reg, count_next;

    logic                accept;
    logic                clr_last;
    logic                clr_in_tbl;
    logic                clr_in_hist;

    // ---------------- decode helpers ----------------
    logic                range_bad;
    logic                same_xtal;
    logic                keep_order;
    logic                is_delayed;
    logic [BW-1:0]       lb, hb;
    logic [XW-1:0]       lc, hc;
    logic [TBL_AW-1:0]   pair_key;
    logic                load_ok;
    logic                idx_ok;
    logic                entry_bad;
    logic [CW-1:0]       hist_rdata;
    logic [CW-1:0]       hist_inc;

    assign busy   = (state_reg != sgb_pkg::ST_IDLE);
    assign accept = start && !busy;

    assign clr_last    = (clr_cnt_reg == CLR_CW'(CLR_DEPTH - 1));
    assign clr_in_tbl  = ({1'b0, clr_cnt_reg} < (CLR_CW + 1)'(PAIR_DEPTH));
    assign clr_in_hist = ({1'b0, clr_cnt_reg} < (CLR_CW + 1)'(SINO_BINS));

    assign range_bad = ({1'b0, bf_reg} >= (BW + 1)'(NUM_BLOCKS))
                    || ({1'b0, bs_reg} >= (BW + 1)'(NUM_BLOCKS))
                    || ({1'b0, cf_reg} >= (XW + 1)'(CPB))
                    || ({1'b0, cs_reg} >= (XW + 1)'(CPB));
    assign same_xtal  = (bf_reg == bs_reg) && (cf_reg == cs_reg);
    assign keep_order = (bf_reg < bs_reg) || ((bf_reg == bs_reg) && (cf_reg <= cs_reg));
    assign lb = keep_order ? bf_reg : bs_reg;
    assign hb = keep_order ? bs_reg : bf_reg;
    assign lc = keep_order ? cf_reg : cs_reg;
    assign hc = keep_order ? cs_reg : cf_reg;

    // Constant-stride multiplies only; narrow operands
    assign pair_key = TBL_AW'(32'(lb) * LB_STRIDE + 32'(hb) * HB_STRIDE
                            + 32'(lc) * CPB + 32'(hc));

    assign is_delayed = (action_reg == sgb_pkg::ACT_DELAYED)
                     || (action_reg == sgb_pkg::ACT_RD_DELAYED);
    assign load_ok    = ({1'b0, tkey_reg} < (sgb_pkg::TKEY_W + 1)'(PAIR_DEPTH));
    assign idx_ok     = ({1'b0, bidx_reg} < (sgb_pkg::BIN_W + 1)'(SINO_BINS));
    assign entry_bad  = tbl_rdata_reg[TW-1] || (tbl_rdata_reg >= TW'(SINO_BINS));
    assign hist_rdata = is_delayed ? d_rdata_reg : p_rdata_reg;
    assign hist_inc   = hist_rdata + CW'(1);

    // ---------------- memory ports ----------------
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            pair_table[tbl_addr] <= tbl_wdata;
        end
        tbl_rdata_reg <= pair_table[tbl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            prompt_hist[hist_addr] <= hist_wdata;
        end
        p_rdata_reg <= prompt_hist[hist_addr];
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            delayed_hist[hist_addr] <= hist_wdata;
        end
        d_rdata_reg <= delayed_hist[hist_addr];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgb_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = sgb_pkg::ST_IDLE;
                end
            end
            sgb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sgb_pkg::ST_DECODE;
                end
            end
            sgb_pkg::ST_DECODE:
            begin
                state_next = sgb_pkg::ST_IDLE;
                case (action_reg)
                    sgb_pkg::ACT_PROMPT, sgb_pkg::ACT_DELAYED:
                    begin
                        if (!range_bad && !(is_delayed && same_xtal))
                        begin
                            state_next = sgb_pkg::ST_TABLE;
                        end
                    end
                    sgb_pkg::ACT_RD_PROMPT, sgb_pkg::ACT_RD_DELAYED:
                    begin
                        if (idx_ok)
                        begin
                            state_next = sgb_pkg::ST_HIST;
                        end
                    end
                    default:
                    begin
                        state_next = sgb_pkg::ST_IDLE;
                    end
                endcase
            end
            sgb_pkg::ST_TABLE:
            begin
                state_next = entry_bad ? sgb_pkg::ST_IDLE : sgb_pkg::ST_HIST;
            end
            sgb_pkg::ST_HIST:
            begin
                state_next = sgb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sgb_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- memory control and results ----------------
    always_comb
    begin
        tbl_we        = 1'b0;
        tbl_addr      = pair_key;
        tbl_wdata     = tval_reg;
        p_we          = 1'b0;
        d_we          = 1'b0;
        hist_addr     = bin_reg;
        hist_wdata    = hist_inc;
        bin_next      = bin_reg;
        done_next     = 1'b0;
        status_next   = sgb_pkg::STAT_DONE;
        bin_used_next = '0;
        count_next    = '0;
        case (state_reg)
            sgb_pkg::ST_CLEAR:
            begin
                tbl_addr   = clr_cnt_reg[TBL_AW-1:0];
                tbl_wdata  = '0;
                tbl_we     = clr_in_tbl;
                hist_addr  = clr_cnt_reg[HIST_AW-1:0];
                hist_wdata = '0;
                p_we       = clr_in_hist;
                d_we       = clr_in_hist;
            end
            sgb_pkg::ST_DECODE:
            begin
                case (action_reg)
                    sgb_pkg::ACT_PROMPT, sgb_pkg::ACT_DELAYED:
                    begin
                        // table read at pair_key is issued by default
                        if (range_bad)
                        begin
                            done_next   = 1'b1;
                            status_next = sgb_pkg::STAT_RANGE;
                        end
                        else if (is_delayed && same_xtal)
                        begin
                            done_next   = 1'b1;
                            status_next = sgb_pkg::STAT_SAME;
                        end
                    end
                    sgb_pkg::ACT_LOAD:
                    begin
                        tbl_addr  = tkey_reg[TBL_AW-1:0];
                        tbl_we    = load_ok;
                        done_next = 1'b1;
                    end
                    sgb_pkg::ACT_RD_PROMPT, sgb_pkg::ACT_RD_DELAYED:
                    begin
                        hist_addr = bidx_reg[HIST_AW-1:0];
                        bin_next  = bidx_reg[HIST_AW-1:0];
                        if (!idx_ok)
                        begin
                            done_next   = 1'b1;
                            status_next = sgb_pkg::STAT_NOBIN;
                        end
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            sgb_pkg::ST_TABLE:
            begin
                hist_addr = tbl_rdata_reg[HIST_AW-1:0];
                bin_next  = tbl_rdata_reg[HIST_AW-1:0];
                if (entry_bad)
                begin
                    done_next   = 1'b1;
                    status_next = sgb_pkg::STAT_NOBIN;
                end
            end
            sgb_pkg::ST_HIST:
            begin
                done_next     = 1'b1;
                bin_used_next = sgb_pkg::BIN_W'(bin_reg);
                if ((action_reg == sgb_pkg::ACT_PROMPT) || (action_reg == sgb_pkg::ACT_DELAYED))
                begin
                    p_we       = !is_delayed;
                    d_we       = is_delayed;
                    count_next = hist_inc;
                end
                else
                begin
                    count_next = hist_rdata;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sgb_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == sgb_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_CW'(1);
            end
        end
    end

    // Request capture and result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            bf_reg     <= block_first;
            cf_reg     <= crystal_first;
            bs_reg     <= block_second;
            cs_reg     <= crystal_second;
            tkey_reg   <= table_key;
            tval_reg   <= table_value;
            bidx_reg   <= bin_index;
        end
        bin_reg      <= bin_next;
        status_reg   <= status_next;
        bin_used_reg <= bin_used_next;
        count_reg    <= count_next;
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign bin_used = bin_used_reg;
    assign count    = count_reg;

    // ---------------- assertions ----------------
    `include "assert_macros.svh"

    `ASSERT_CLK(a_done_from_work, done_reg |-> ($past(state_reg == sgb_pkg::ST_DECODE) || $past(state_reg == sgb_pkg::ST_TABLE) || $past(state_reg == sgb_pkg::ST_HIST)), "result strobe without a request in work")
    `ASSERT_CLK(a_err_fields_zero, (done_reg && (status_reg != sgb_pkg::STAT_DONE)) |-> ((bin_used_reg == '0) && (count_reg == '0)), "error result carries data")
    `ASSERT_CLK(a_accept_decode, accept |=> (state_reg == sgb_pkg::ST_DECODE), "accepted request not decoded")
    `ASSERT_CLK(a_hist_we_state, (p_we || d_we) |-> ((state_reg == sgb_pkg::ST_HIST) || (state_reg == sgb_pkg::ST_CLEAR)), "histogram written outside write-back")
    `ASSERT_CLK(a_hist_we_one, (state_reg == sgb_pkg::ST_HIST) |-> !(p_we && d_we), "both histograms written by one request")

endmodule

`default_nettype wire
